### rtl/core/gastar_pkg.sv
// Shared types and constants of the grid A* next-step core.
package gastar_pkg;

   localparam int GRID_ROWS_DEF = 64;
   localparam int GRID_COLS_DEF = 64;
   localparam int LIST_SIZE_DEF = 1024;

   localparam int FIELD_W    = 6;
   localparam int G_W        = 8;
   localparam int SEED_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [G_W-1:0]       MAX_DEPTH_RST = 8'd50;
   localparam logic [SEED_W-1:0]    TIE_SEED_RST  = 16'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DEPTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIE_SEED  = 2'd1;

   typedef enum logic [1:0] {
      STAT_STEP    = 2'd0,
      STAT_NO_STEP = 2'd1,
      STAT_DEPTH   = 2'd2,
      STAT_NO_PATH = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INIT,
      ST_PICK,
      ST_TAKE,
      ST_NBR,
      ST_NCHK,
      ST_CSCAN,
      ST_OSCAN,
      ST_OADD,
      ST_FINISH
   } state_type;

endpackage

### rtl/core/gastar_req_if.sv
// Request channel carrying map writes and path queries.
interface gastar_req_if;
   logic                           valid;
   logic                           ready;
   logic                           func;
   logic [gastar_pkg::FIELD_W-1:0] cell_row;
   logic [gastar_pkg::FIELD_W-1:0] cell_col;
   logic                           cell_blocked;
   logic [gastar_pkg::FIELD_W-1:0] src_row;
   logic [gastar_pkg::FIELD_W-1:0] src_col;
   logic [gastar_pkg::FIELD_W-1:0] dst_row;
   logic [gastar_pkg::FIELD_W-1:0] dst_col;

   modport source (output valid, func, cell_row, cell_col, cell_blocked,
                   src_row, src_col, dst_row, dst_col, input ready);
   modport sink (input valid, func, cell_row, cell_col, cell_blocked,
                 src_row, src_col, dst_row, dst_col, output ready);
endinterface

### rtl/core/gastar_rsp_if.sv
// Response channel carrying the next step of a path query.
interface gastar_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     status;
   logic [gastar_pkg::FIELD_W-1:0] next_row;
   logic [gastar_pkg::FIELD_W-1:0] next_col;

   modport source (output valid, status, next_row, next_col, input ready);
   modport sink (input valid, status, next_row, next_col, output ready);
endinterface

### rtl/core/grid_astar_next_step_core.sv
// Grid A* next-step engine with map, open and closed stores in memories.
//
//   channel   | direction | content
//   req_ch    | in        | map cell write (func 0) or path query (func 1)
//   rsp_ch    | out       | status and goal parent cell, one per query
//   csr_*     | in        | max_depth (index 0), tie_seed (index 1)
//
// A map write goes straight into the map memory. A query loads the start slot, then per
// expansion runs a pick scan over the U used open slots and a take step, and per
// neighbor two steps, plus a scan of the C closed slots when it is passable and an
// open scan over the U used slots and an add step when it is not closed and within the
// depth limit; a finish step ends it. After reset the map is cleared one cell per cycle,
// with requests held off. A finished query waits in place while the previous response
// is still pending.
module grid_astar_next_step_core #(
   parameter int GRID_ROWS = gastar_pkg::GRID_ROWS_DEF,
   parameter int GRID_COLS = gastar_pkg::GRID_COLS_DEF,
   parameter int LIST_SIZE = gastar_pkg::LIST_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   gastar_req_if.sink                        req_ch,
   gastar_rsp_if.source                      rsp_ch,
   input  logic                              csr_we,
   input  logic [gastar_pkg::CSR_IDX_W-1:0]  csr_idx,
   input  logic [gastar_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int DIM_A     = (GRID_ROWS > GRID_COLS) ? GRID_ROWS : GRID_COLS;
   localparam int DIM_MAX   = (DIM_A > 64) ? DIM_A : 64;
   localparam int CW        = $clog2(DIM_MAX + 1) + 1;
   localparam int GW        = gastar_pkg::G_W;
   localparam int FW        = CW + GW + 1;
   localparam int IW        = $clog2(LIST_SIZE);
   localparam int NW        = $clog2(LIST_SIZE + 1);
   localparam int MAP_DEPTH = GRID_ROWS * GRID_COLS;
   localparam int MAW       = $clog2(MAP_DEPTH);
   localparam int CLW       = $clog2(MAP_DEPTH + 1);
   localparam int FLD       = gastar_pkg::FIELD_W;

   typedef struct packed {
      logic                 vld;
      logic signed [CW-1:0] row;
      logic signed [CW-1:0] col;
      logic [GW-1:0]        g;
      logic [FW-1:0]        f;
      logic signed [CW-1:0] prow;
      logic signed [CW-1:0] pcol;
   } oslot_type;

   function automatic logic [CW:0] absd(input logic signed [CW-1:0] a,
                                        input logic signed [CW-1:0] b);
      logic signed [CW:0] d;
      begin
         d = {a[CW-1], a} - {b[CW-1], b};
         absd = d[CW] ? (~d + 1'b1) : d;
      end
   endfunction

   gastar_pkg::state_type  state_ff, state_in;
   gastar_pkg::status_type stat_ff, stat_in;

   oslot_type            open_mem [LIST_SIZE];
   oslot_type            open_rd_ff;
   logic [2*CW-1:0]      closed_mem [LIST_SIZE];
   logic [2*CW-1:0]      closed_rd_ff;
   logic                 map_mem [MAP_DEPTH];
   logic                 map_rd_ff;

   logic signed [CW-1:0] dst_row_ff, dst_row_in, dst_col_ff, dst_col_in;
   oslot_type            cur_ff, cur_in, best_ff, best_in;
   logic [1:0]           k_ff, k_in;
   logic [NW-1:0]        idx_ff, idx_in, ouse_ff, ouse_in, ocnt_ff, ocnt_in;
   logic [NW-1:0]        ccnt_ff, ccnt_in;
   logic                 pend_ff, pend_in;
   logic [IW-1:0]        pidx_ff, pidx_in, best_idx_ff, best_idx_in;
   logic [IW-1:0]        jidx_ff, jidx_in, fidx_ff, fidx_in;
   logic [GW-1:0]        jg_ff, jg_in;
   logic                 have_ff, have_in, found_ff, found_in, fhave_ff, fhave_in;
   logic [15:0]          lfsr_ff, lfsr_in;
   logic [CLW-1:0]       clr_ff, clr_in;
   logic [GW-1:0]        max_depth_ff, max_depth_in;
   logic [gastar_pkg::SEED_W-1:0] tie_seed_ff, tie_seed_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [FLD-1:0]       rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;

   logic                 req_acc, map_we, is_scan, scan_done, k_last, rsp_free;
   logic [NW-1:0]        lim;
   logic [IW-1:0]        rd_addr;
   logic [MAW-1:0]       map_waddr, map_raddr;
   logic signed [CW-1:0] nbr_row, nbr_col;
   logic                 on_grid, is_goal, nbr_pass, cur_goal, lfsr_b;
   logic [GW:0]          nbr_g;
   logic [FW-1:0]        nbr_f, start_f;
   oslot_type            nslot, open_wdata;
   logic                 open_we, closed_we;
   logic [IW-1:0]        open_waddr;

   assign req_acc   = req_ch.valid && req_ch.ready;
   assign map_we    = req_acc && !req_ch.func
                      && (int'(req_ch.cell_row) < GRID_ROWS)
                      && (int'(req_ch.cell_col) < GRID_COLS);
   assign map_waddr = MAW'(int'(req_ch.cell_row) * GRID_COLS + int'(req_ch.cell_col));

   assign is_scan   = (state_ff == gastar_pkg::ST_PICK) || (state_ff == gastar_pkg::ST_CSCAN)
                      || (state_ff == gastar_pkg::ST_OSCAN);
   assign lim       = (state_ff == gastar_pkg::ST_CSCAN) ? ccnt_ff : ouse_ff;
   assign scan_done = (idx_ff == lim) && !pend_ff;
   assign rd_addr   = idx_ff[IW-1:0];
   assign k_last    = (k_ff == 2'd3);
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      nbr_row = cur_ff.row;
      nbr_col = cur_ff.col;
      case (k_ff)
         2'd0:    nbr_row = cur_ff.row - CW'(1);
         2'd1:    nbr_row = cur_ff.row + CW'(1);
         2'd2:    nbr_col = cur_ff.col + CW'(1);
         default: nbr_col = cur_ff.col - CW'(1);
      endcase
   end

   assign on_grid   = (nbr_row >= 0) && (nbr_row < GRID_ROWS)
                      && (nbr_col >= 0) && (nbr_col < GRID_COLS);
   assign is_goal   = (nbr_row == dst_row_ff) && (nbr_col == dst_col_ff);
   assign nbr_pass  = (on_grid && !map_rd_ff) || is_goal;
   assign map_raddr = MAW'(int'(nbr_row) * GRID_COLS + int'(nbr_col));
   assign nbr_g     = {1'b0, cur_ff.g} + (GW + 1)'(1);
   assign nbr_f     = FW'(nbr_g) + FW'(absd(nbr_row, dst_row_ff))
                      + FW'(absd(nbr_col, dst_col_ff));
   assign start_f   = FW'(absd(cur_ff.row, dst_row_ff)) + FW'(absd(cur_ff.col, dst_col_ff));
   assign cur_goal  = (best_ff.row == dst_row_ff) && (best_ff.col == dst_col_ff);
   assign lfsr_b    = lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5];

   always_comb begin
      nslot      = '0;
      nslot.vld  = 1'b1;
      nslot.row  = nbr_row;
      nslot.col  = nbr_col;
      nslot.g    = nbr_g[GW-1:0];
      nslot.f    = nbr_f;
      nslot.prow = cur_ff.row;
      nslot.pcol = cur_ff.col;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gastar_pkg::ST_CLEAR: begin
            if (clr_ff == CLW'(MAP_DEPTH - 1)) state_in = gastar_pkg::ST_IDLE;
         end
         gastar_pkg::ST_IDLE: begin
            if (req_acc && req_ch.func) state_in = gastar_pkg::ST_INIT;
         end
         gastar_pkg::ST_INIT: state_in = gastar_pkg::ST_PICK;
         gastar_pkg::ST_PICK: begin
            if (scan_done) state_in = gastar_pkg::ST_TAKE;
         end
         gastar_pkg::ST_TAKE: begin
            state_in = cur_goal ? gastar_pkg::ST_FINISH : gastar_pkg::ST_NBR;
         end
         gastar_pkg::ST_NBR: state_in = gastar_pkg::ST_NCHK;
         gastar_pkg::ST_NCHK, gastar_pkg::ST_CSCAN, gastar_pkg::ST_OADD: begin
            if ((state_ff == gastar_pkg::ST_NCHK && nbr_pass)
                || (state_ff == gastar_pkg::ST_CSCAN && !scan_done)) begin
               if (state_ff == gastar_pkg::ST_NCHK) state_in = gastar_pkg::ST_CSCAN;
            end else if (state_ff == gastar_pkg::ST_CSCAN && !found_ff
                         && nbr_g > {1'b0, max_depth_ff}) begin
               state_in = gastar_pkg::ST_FINISH;
            end else if (state_ff == gastar_pkg::ST_CSCAN && !found_ff) begin
               state_in = gastar_pkg::ST_OSCAN;
            end else if (!k_last) begin
               state_in = gastar_pkg::ST_NBR;
            end else if (ocnt_in == '0) begin
               state_in = gastar_pkg::ST_FINISH;
            end else begin
               state_in = gastar_pkg::ST_PICK;
            end
         end
         gastar_pkg::ST_OSCAN: begin
            if (scan_done) state_in = gastar_pkg::ST_OADD;
         end
         gastar_pkg::ST_FINISH: begin
            if (rsp_free) state_in = gastar_pkg::ST_IDLE;
         end
         default: state_in = gastar_pkg::ST_IDLE;
      endcase
   end

   // Handshake and memory write strobes.
   always_comb begin
      req_ch.ready = (state_ff == gastar_pkg::ST_IDLE);
      open_we      = 1'b0;
      open_waddr   = '0;
      open_wdata   = nslot;
      closed_we    = 1'b0;
      unique case (state_ff)
         gastar_pkg::ST_INIT: begin
            open_we         = 1'b1;
            open_wdata      = '0;
            open_wdata.vld  = 1'b1;
            open_wdata.row  = cur_ff.row;
            open_wdata.col  = cur_ff.col;
            open_wdata.f    = start_f;
         end
         gastar_pkg::ST_TAKE: begin
            open_we        = 1'b1;
            open_waddr     = best_idx_ff;
            open_wdata     = best_ff;
            open_wdata.vld = 1'b0;
            closed_we      = (ccnt_ff != NW'(LIST_SIZE));
         end
         gastar_pkg::ST_OADD: begin
            if (found_ff) begin
               open_we    = nbr_g < {1'b0, jg_ff};
               open_waddr = jidx_ff;
            end else if (fhave_ff) begin
               open_we    = 1'b1;
               open_waddr = fidx_ff;
            end else begin
               open_we    = (ouse_ff != NW'(LIST_SIZE));
               open_waddr = ouse_ff[IW-1:0];
            end
         end
         default: begin
            open_we = 1'b0;
         end
      endcase
   end

   // Datapath and counters.
   always_comb begin
      dst_row_in    = dst_row_ff;
      dst_col_in    = dst_col_ff;
      cur_in        = cur_ff;
      best_in       = best_ff;
      k_in          = k_ff;
      idx_in        = '0;
      pend_in       = 1'b0;
      pidx_in       = idx_ff[IW-1:0];
      ouse_in       = ouse_ff;
      ocnt_in       = ocnt_ff;
      ccnt_in       = ccnt_ff;
      best_idx_in   = best_idx_ff;
      jidx_in       = jidx_ff;
      fidx_in       = fidx_ff;
      jg_in         = jg_ff;
      have_in       = have_ff;
      found_in      = found_ff;
      fhave_in      = fhave_ff;
      lfsr_in       = lfsr_ff;
      clr_in        = clr_ff;
      stat_in       = stat_ff;
      max_depth_in  = max_depth_ff;
      tie_seed_in   = tie_seed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;

      if (csr_we) begin
         unique case (csr_idx)
            gastar_pkg::CSR_MAX_DEPTH: max_depth_in = csr_wdata[GW-1:0];
            gastar_pkg::CSR_TIE_SEED:  tie_seed_in  = csr_wdata;
            default:                   max_depth_in = max_depth_ff;
         endcase
      end

      if (is_scan && !scan_done) begin
         pend_in = (idx_ff != lim);
         idx_in  = (idx_ff != lim) ? idx_ff + NW'(1) : idx_ff;
      end

      case (state_ff)
         gastar_pkg::ST_CLEAR: clr_in = clr_ff + CLW'(1);
         gastar_pkg::ST_IDLE: begin
            if (req_acc && req_ch.func) begin
               dst_row_in = $signed(CW'(req_ch.dst_row));
               dst_col_in = $signed(CW'(req_ch.dst_col));
               cur_in.row = $signed(CW'(req_ch.src_row));
               cur_in.col = $signed(CW'(req_ch.src_col));
               cur_in.g   = '0;
            end
         end
         gastar_pkg::ST_INIT: begin
            ouse_in = NW'(1);
            ocnt_in = NW'(1);
            ccnt_in = '0;
            have_in = 1'b0;
            lfsr_in = (tie_seed_ff == '0) ? 16'd1 : tie_seed_ff;
         end
         gastar_pkg::ST_PICK: begin
            if (pend_ff && open_rd_ff.vld) begin
               if (!have_ff || open_rd_ff.f < best_ff.f) begin
                  have_in     = 1'b1;
                  best_in     = open_rd_ff;
                  best_idx_in = pidx_ff;
               end else if (open_rd_ff.f == best_ff.f) begin
                  lfsr_in = {lfsr_b, lfsr_ff[15:1]};
                  if (lfsr_b) begin
                     best_in     = open_rd_ff;
                     best_idx_in = pidx_ff;
                  end
               end
            end
         end
         gastar_pkg::ST_TAKE: begin
            cur_in  = best_ff;
            have_in = 1'b0;
            ocnt_in = ocnt_ff - NW'(1);
            k_in    = 2'd0;
            if (ccnt_ff != NW'(LIST_SIZE)) ccnt_in = ccnt_ff + NW'(1);
            if (cur_goal) begin
               stat_in = (best_ff.prow == '0 && best_ff.pcol == '0)
                         ? gastar_pkg::STAT_NO_STEP : gastar_pkg::STAT_STEP;
            end
         end
         gastar_pkg::ST_NCHK: begin
            found_in = 1'b0;
            if (!nbr_pass) begin
               k_in = k_ff + 2'd1;
               if (k_last) stat_in = gastar_pkg::STAT_NO_PATH;
            end
         end
         gastar_pkg::ST_CSCAN: begin
            if (pend_ff && closed_rd_ff == {nbr_row, nbr_col}) found_in = 1'b1;
            if (scan_done) begin
               if (found_ff) begin
                  k_in = k_ff + 2'd1;
                  if (k_last) stat_in = gastar_pkg::STAT_NO_PATH;
               end else begin
                  stat_in  = gastar_pkg::STAT_DEPTH;
                  found_in = 1'b0;
                  fhave_in = 1'b0;
               end
            end
         end
         gastar_pkg::ST_OSCAN: begin
            if (pend_ff) begin
               if (open_rd_ff.vld && open_rd_ff.row == nbr_row
                   && open_rd_ff.col == nbr_col) begin
                  found_in = 1'b1;
                  jidx_in  = pidx_ff;
                  jg_in    = open_rd_ff.g;
               end
               if (!open_rd_ff.vld && !fhave_ff) begin
                  fhave_in = 1'b1;
                  fidx_in  = pidx_ff;
               end
            end
         end
         gastar_pkg::ST_OADD: begin
            k_in = k_ff + 2'd1;
            if (k_last) stat_in = gastar_pkg::STAT_NO_PATH;
            if (!found_ff) begin
               if (fhave_ff) begin
                  ocnt_in = ocnt_ff + NW'(1);
               end else if (ouse_ff != NW'(LIST_SIZE)) begin
                  ocnt_in = ocnt_ff + NW'(1);
                  ouse_in = ouse_ff + NW'(1);
               end
            end
         end
         gastar_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_row_in    = (stat_ff == gastar_pkg::STAT_STEP) ? cur_ff.prow[FLD-1:0] : '0;
               rsp_col_in    = (stat_ff == gastar_pkg::STAT_STEP) ? cur_ff.pcol[FLD-1:0] : '0;
            end
         end
         default: begin
            k_in = k_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gastar_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         max_depth_ff <= gastar_pkg::MAX_DEPTH_RST;
         tie_seed_ff  <= gastar_pkg::TIE_SEED_RST;
         ouse_ff      <= '0;
         ocnt_ff      <= '0;
         ccnt_ff      <= '0;
         lfsr_ff      <= 16'd1;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         max_depth_ff <= max_depth_in;
         tie_seed_ff  <= tie_seed_in;
         ouse_ff      <= ouse_in;
         ocnt_ff      <= ocnt_in;
         ccnt_ff      <= ccnt_in;
         lfsr_ff      <= lfsr_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      dst_row_ff    <= dst_row_in;
      dst_col_ff    <= dst_col_in;
      cur_ff        <= cur_in;
      best_ff       <= best_in;
      k_ff          <= k_in;
      pidx_ff       <= pidx_in;
      best_idx_ff   <= best_idx_in;
      jidx_ff       <= jidx_in;
      fidx_ff       <= fidx_in;
      jg_ff         <= jg_in;
      have_ff       <= have_in;
      found_ff      <= found_in;
      fhave_ff      <= fhave_in;
      stat_ff       <= stat_in;
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
   end

   always_ff @(posedge clock) begin
      if (open_we) open_mem[open_waddr] <= open_wdata;
      open_rd_ff <= open_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (closed_we) closed_mem[ccnt_ff[IW-1:0]] <= {best_ff.row, best_ff.col};
      closed_rd_ff <= closed_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == gastar_pkg::ST_CLEAR) begin
         map_mem[clr_ff[MAW-1:0]] <= 1'b0;
      end else if (map_we) begin
         map_mem[map_waddr] <= req_ch.cell_blocked;
      end
      map_rd_ff <= map_mem[map_raddr];
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.next_row = rsp_row_ff;
   assign rsp_ch.next_col = rsp_col_ff;

   a_ocnt_le_ouse: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= ouse_ff)
      else $error("open count exceeds used open slots");

   a_ccnt_bound: assert property (@(posedge clock) disable iff (reset)
      ccnt_ff <= NW'(LIST_SIZE))
      else $error("closed count beyond store size");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_ch.func |=> !req_ch.ready)
      else $error("query request did not start a search");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != gastar_pkg::STAT_STEP
      |-> rsp_ch.next_row == '0 && rsp_ch.next_col == '0)
      else $error("nonzero step on a no-step response");

endmodule

### verif/gastar_next_step_checker.sv
// Checker for the grid A* next-step core: predicts each query result and compares responses.
module gastar_next_step_checker (
   input  logic                              clock,
   input  logic                              reset,
   gastar_req_if                             req_mon,
   gastar_rsp_if                             rsp_mon,
   input  logic                              csr_we,
   input  logic [gastar_pkg::CSR_IDX_W-1:0]  csr_idx,
   input  logic [gastar_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                                fail_count,
   output int                                pending
);

   localparam int ROWS  = gastar_pkg::GRID_ROWS_DEF;
   localparam int COLS  = gastar_pkg::GRID_COLS_DEF;
   localparam int SLOTS = gastar_pkg::LIST_SIZE_DEF;
   localparam int FW    = gastar_pkg::FIELD_W;

   typedef struct {
      gastar_pkg::status_type status;
      logic [FW-1:0]          next_row;
      logic [FW-1:0]          next_col;
   } step_result_type;

   bit               occupied [ROWS][COLS];
   bit               op_valid [SLOTS];
   int               op_row [SLOTS];
   int               op_col [SLOTS];
   int               op_g [SLOTS];
   int               op_f [SLOTS];
   int               op_prow [SLOTS];
   int               op_pcol [SLOTS];
   bit               cl_valid [SLOTS];
   int               cl_row [SLOTS];
   int               cl_col [SLOTS];
   int               open_used;
   logic [15:0]      tie_state;
   logic [gastar_pkg::G_W-1:0]    depth_limit;
   logic [gastar_pkg::SEED_W-1:0] seed_value;
   step_result_type  expected_steps[$];

   function automatic bit tie_step();
      bit fb;
      fb = tie_state[0] ^ tie_state[2] ^ tie_state[3] ^ tie_state[5];
      tie_state = {fb, tie_state[15:1]};
      return fb;
   endfunction

   function automatic int abs_gap(int a, int b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic void open_insert(int r, int c, int g, int f, int pr, int pc);
      for (int i = 0; i < SLOTS; i++) begin
         if (!op_valid[i]) begin
            op_valid[i] = 1'b1;
            op_row[i] = r;
            op_col[i] = c;
            op_g[i] = g;
            op_f[i] = f;
            op_prow[i] = pr;
            op_pcol[i] = pc;
            open_used++;
            return;
         end
      end
   endfunction

   function automatic void closed_insert(int r, int c);
      for (int i = 0; i < SLOTS; i++) begin
         if (!cl_valid[i]) begin
            cl_valid[i] = 1'b1;
            cl_row[i] = r;
            cl_col[i] = c;
            return;
         end
      end
   endfunction

   function automatic bit is_closed(int r, int c);
      for (int i = 0; i < SLOTS; i++)
         if (cl_valid[i] && cl_row[i] == r && cl_col[i] == c) return 1'b1;
      return 1'b0;
   endfunction

   function automatic int open_index(int r, int c);
      for (int i = 0; i < SLOTS; i++)
         if (op_valid[i] && op_row[i] == r && op_col[i] == c) return i;
      return -1;
   endfunction

   function automatic int best_open();
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (op_valid[i]) begin
            if (best < 0) best = i;
            else if (op_f[i] < op_f[best]) best = i;
            else if (op_f[i] == op_f[best] && tie_step()) best = i;
         end
      end
      return best;
   endfunction

   function automatic step_result_type search_next_step(int sr, int sc, int gr, int gc);
      step_result_type res;
      int              b, r, c, g, j, cr, cc, cg, cpr, cpc;
      int              dr[4];
      int              dc[4];
      bit              passable;
      dr = '{-1, 1, 0, 0};
      dc = '{0, 0, 1, -1};
      res.status = gastar_pkg::STAT_NO_PATH;
      res.next_row = '0;
      res.next_col = '0;
      for (int i = 0; i < SLOTS; i++) begin
         op_valid[i] = 1'b0;
         cl_valid[i] = 1'b0;
      end
      open_used = 0;
      tie_state = (seed_value == '0) ? 16'd1 : seed_value;
      open_insert(sr, sc, 0, abs_gap(sr, gr) + abs_gap(sc, gc), 0, 0);
      while (open_used != 0) begin
         b = best_open();
         if (b < 0) break;
         cr = op_row[b];
         cc = op_col[b];
         cg = op_g[b];
         cpr = op_prow[b];
         cpc = op_pcol[b];
         op_valid[b] = 1'b0;
         open_used--;
         closed_insert(cr, cc);
         if (cr == gr && cc == gc) begin
            if (cpr == 0 && cpc == 0) begin
               res.status = gastar_pkg::STAT_NO_STEP;
            end else begin
               res.status = gastar_pkg::STAT_STEP;
               res.next_row = cpr[FW-1:0];
               res.next_col = cpc[FW-1:0];
            end
            return res;
         end
         for (int k = 0; k < 4; k++) begin
            r = cr + dr[k];
            c = cc + dc[k];
            passable = (r >= 0 && c >= 0 && r < ROWS && c < COLS) && !occupied[r][c];
            if (!passable && !(r == gr && c == gc)) continue;
            if (is_closed(r, c)) continue;
            g = cg + 1;
            if (g > int'(depth_limit)) begin
               res.status = gastar_pkg::STAT_DEPTH;
               return res;
            end
            j = open_index(r, c);
            if (j < 0) begin
               open_insert(r, c, g, g + abs_gap(r, gr) + abs_gap(c, gc), cr, cc);
            end else if (g < op_g[j]) begin
               op_g[j] = g;
               op_f[j] = g + abs_gap(r, gr) + abs_gap(c, gc);
               op_prow[j] = cr;
               op_pcol[j] = cc;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      step_result_type want;
      if (reset) begin
         for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++) occupied[r][c] = 1'b0;
         depth_limit = gastar_pkg::MAX_DEPTH_RST;
         seed_value = gastar_pkg::TIE_SEED_RST;
         expected_steps.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_idx == gastar_pkg::CSR_MAX_DEPTH)
               depth_limit = csr_wdata[gastar_pkg::G_W-1:0];
            else if (csr_idx == gastar_pkg::CSR_TIE_SEED)
               seed_value = csr_wdata[gastar_pkg::SEED_W-1:0];
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_steps.size() == 0) begin
               $error("response with no query outstanding: status %0d", rsp_mon.status);
               fail_count++;
            end else begin
               want = expected_steps.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_mon.status);
                  fail_count++;
               end
               if (rsp_mon.next_row !== want.next_row) begin
                  $error("next_row: expected %0d, actual %0d", want.next_row,
                         rsp_mon.next_row);
                  fail_count++;
               end
               if (rsp_mon.next_col !== want.next_col) begin
                  $error("next_col: expected %0d, actual %0d", want.next_col,
                         rsp_mon.next_col);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func == 1'b0)
               occupied[req_mon.cell_row][req_mon.cell_col] = req_mon.cell_blocked;
            else
               expected_steps.push_back(search_next_step(req_mon.src_row,
                  req_mon.src_col, req_mon.dst_row, req_mon.dst_col));
         end
      end
      pending = expected_steps.size();
   end
endmodule

### verif/tb_grid_astar_next_step_core.sv
// Testbench top for the grid A* next-step core: clock, reset, stimulus and verdict.
module tb_grid_astar_next_step_core;

   localparam int STALL_LIMIT = 5000000;
   localparam int FW          = gastar_pkg::FIELD_W;
   localparam int IDX_W       = gastar_pkg::CSR_IDX_W;
   localparam int DATA_W      = gastar_pkg::CSR_DATA_W;
   localparam logic [IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [IDX_W-1:0]      csr_idx;
   logic [DATA_W-1:0]     csr_wdata;
   int                    fail_count;
   int                    pending;
   int                    quiet_cycles;
   bit                    idle_on;
   bit                    long_hold;

   gastar_req_if req_ch ();
   gastar_rsp_if rsp_ch ();

   grid_astar_next_step_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   gastar_next_step_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_we     (csr_we),
      .csr_idx    (csr_idx),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The response side stalls in random bursts, or holds off once for a long stretch.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold && !hold_done) begin
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (3000) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(bit func, int cr, int cc, bit blk, int sr, int sc, int gr,
                               int gc);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= func;
      req_ch.cell_row <= cr[FW-1:0];
      req_ch.cell_col <= cc[FW-1:0];
      req_ch.cell_blocked <= blk;
      req_ch.src_row <= sr[FW-1:0];
      req_ch.src_col <= sc[FW-1:0];
      req_ch.dst_row <= gr[FW-1:0];
      req_ch.dst_col <= gc[FW-1:0];
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic map_write(int r, int c, bit blk);
      send_request(1'b0, r, c, blk, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 63));
   endtask

   task automatic query(int sr, int sc, int gr, int gc);
      send_request(1'b1, $urandom_range(0, 63), $urandom_range(0, 63),
                   1'($urandom_range(0, 1)), sr, sc, gr, gc);
   endtask

   task automatic write_csr(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int near(int v);
      int x;
      x = v + int'($urandom_range(0, 12)) - 6;
      return (x < 0) ? 0 : (x > 63) ? 63 : x;
   endfunction

   initial begin
      int sr, sc;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_idx = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.func = 1'b0;
      req_ch.cell_row = '0;
      req_ch.cell_col = '0;
      req_ch.cell_blocked = 1'b0;
      req_ch.src_row = '0;
      req_ch.src_col = '0;
      req_ch.dst_row = '0;
      req_ch.dst_col = '0;
      quiet_cycles = 0;
      idle_on = 1'b1;
      long_hold = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: start on goal, parent at origin, grid edges.
      query(5, 5, 5, 5);
      query(0, 0, 0, 1);
      query(0, 1, 0, 3);
      query(63, 63, 62, 62);
      query(63, 0, 60, 3);

      write_csr(gastar_pkg::CSR_MAX_DEPTH, 16'd1);
      write_csr(gastar_pkg::CSR_TIE_SEED, 16'd0);
      write_csr(CSR_SPARE_LO, 16'hFFFF);
      write_csr(CSR_SPARE_HI, 16'hA5A5);
      query(10, 10, 10, 13);
      query(10, 10, 10, 11);
      map_write(19, 20, 1'b1);
      map_write(21, 20, 1'b1);
      map_write(20, 21, 1'b1);
      map_write(20, 19, 1'b1);
      query(20, 20, 30, 30);
      map_write(40, 41, 1'b1);
      query(40, 40, 40, 41);
      map_write(19, 20, 1'b0);

      write_csr(gastar_pkg::CSR_MAX_DEPTH, 16'd255);
      write_csr(gastar_pkg::CSR_TIE_SEED, 16'hFFFF);
      query(30, 30, 34, 36);
      query(62, 1, 63, 0);
      query(20, 20, 17, 20);
      map_write(63, 63, 1'b1);
      query(63, 62, 63, 63);
      map_write(63, 63, 1'b0);

      for (int phase = 0; phase < 4; phase++) begin
         write_csr(gastar_pkg::CSR_MAX_DEPTH, 16'($urandom_range(1, 9)));
         write_csr(gastar_pkg::CSR_TIE_SEED, 16'($urandom_range(0, 65535)));
         if (phase == 3) idle_on = 1'b0;
         if (phase == 1) begin
            long_hold = 1'b1;
            for (int i = 0; i < 5; i++) query(3, i, 3, i + 1);
         end
         for (int i = 0; i < 19; i++) begin
            sr = $urandom_range(0, 15);
            sc = $urandom_range(0, 15);
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7: map_write(sr, sc, $urandom_range(0, 2) == 0);
               8: map_write($urandom_range(0, 63), $urandom_range(0, 63),
                            1'($urandom_range(0, 1)));
               9: query($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 63));
               default: query(sr, sc, near(sr), near(sc));
            endcase
         end
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
